// ===== sv/hmth_pkg.sv =====
// ----------------------------------------------------------------------------
// hmth_pkg
// Shared types and constants for the heightmap ground-height query block:
// request kinds, register indexes, store and queue sizing, and the fixed-point constants.
// ----------------------------------------------------------------------------
package hmth_pkg;

    // Request kind carried in tuser on the input stream.
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_HALF_SIZE = 2'd0,
        REG_CELLS_PER = 2'd1,
        REG_GAIN      = 2'd2,
        REG_EYE       = 2'd3
    } t_reg_idx;

    // One in Q0.16 needs a seventeenth bit.
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Height store geometry: 256 x 256, split into four parity banks.
    localparam int IDX_W      = 8;
    localparam int BANK_ADDR_W = 2 * (IDX_W - 1);
    localparam int NUM_BANKS  = 4;

    // Result queue sizing; it must cover the pipeline latency.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = 4;
    localparam int FIFO_CNT_W = 5;

    // Output saturation limit in Q16.16.
    localparam logic [31:0] HEIGHT_MAX = 32'h7FFF_FFFF;

endpackage

// ===== sv/heightmap_triangle_height_query.sv =====
// ----------------------------------------------------------------------------
// heightmap_triangle_height_query
// A query's result reaches the output after passing the pipeline stages
// and the result queue. Throughput: one request per cycle (loads and
// queries mixed) while the result credits allow; the four corner reads of
// a query use one read port on each of four parity banks. A load writes
// the store in stage 4, the same stage where queries read, so request
// order is kept without forwarding.
// Reset clears the registers and the pipeline; the height store is not reset.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_query #(
    parameter int GRID_CELLS  = 255,
    parameter int SAMPLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: sample_col[7:0], sample_row[15:8], sample_value[31:16],
    //        pos_x[63:32], pos_z[95:64]
    input  logic [95:0]  i_s_axis_tdata,
    // tuser: func[0]
    input  logic         i_s_axis_tuser,
    // Output stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: ground_height[31:0]
    output logic [31:0]  o_m_axis_tdata,
    // tuser: off_grid[0]
    output logic         o_m_axis_tuser,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import hmth_pkg::*;

    // Stored sample width: the input carries at most 16 bits.
    localparam int SW        = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam int WPROD_W   = SW + 17;
    localparam int BLEND_W   = WPROD_W + 2;
    localparam int B16_W     = 18;
    localparam int GPROD_W   = B16_W + 32;
    localparam int SCALED_W  = GPROD_W - 15;
    localparam int BANK_DEPTH = 1 << BANK_ADDR_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [30:0] r_half_size;
    logic [31:0] r_cells_per;
    logic [31:0] r_gain;
    logic [30:0] r_eye;
    t_reg_idx    reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_size <= '0;
            r_cells_per <= '0;
            r_gain      <= '0;
            r_eye       <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_HALF_SIZE: r_half_size <= pwdata[30:0];
                REG_CELLS_PER: r_cells_per <= pwdata;
                REG_GAIN:      r_gain      <= pwdata;
                REG_EYE:       r_eye       <= pwdata[30:0];
                default:       r_gain      <= r_gain;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_idx)
            REG_HALF_SIZE: prdata = {1'b0, r_half_size};
            REG_CELLS_PER: prdata = r_cells_per;
            REG_GAIN:      prdata = r_gain;
            REG_EYE:       prdata = {1'b0, r_eye};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: credits cover queries in flight plus queued results.
    // ------------------------------------------------------------------
    logic                  r_credit_q;
    logic [FIFO_CNT_W-1:0] r_credit;
    logic [FIFO_CNT_W-1:0] n_credit;
    logic                  in_acc;
    logic                  out_acc;
    logic                  qry_acc;

    assign o_s_axis_tready = (r_credit < FIFO_CNT_W'(FIFO_DEPTH));
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign qry_acc = in_acc && (t_func'(i_s_axis_tuser) == FUNC_QUERY);
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        n_credit = r_credit;
        if (qry_acc && !out_acc) begin
            n_credit = r_credit + 1'b1;
        end else if (!qry_acc && out_acc) begin
            n_credit = r_credit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit   <= '0;
            r_credit_q <= 1'b0;
        end else begin
            r_credit   <= n_credit;
            r_credit_q <= qry_acc;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline valid bits (stages 1-3 carry loads and queries, later ones
    // carry queries only).
    // ------------------------------------------------------------------
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld, r8_vld;
    t_func r1_func, r2_func, r3_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r1_func <= FUNC_LOAD;
            r2_func <= FUNC_LOAD;
            r3_func <= FUNC_LOAD;
        end else begin
            r1_vld  <= in_acc;
            r1_func <= t_func'(i_s_axis_tuser);
            r2_vld  <= r1_vld;
            r2_func <= r1_func;
            r3_vld  <= r2_vld;
            r3_func <= r2_func;
            r4_vld  <= r3_vld && (r3_func == FUNC_QUERY);
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the request.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  r1_col, r2_col, r3_col;
    logic [IDX_W-1:0]  r1_row, r2_row, r3_row;
    logic [SW-1:0]     r1_val, r2_val, r3_val;
    logic signed [31:0] r1_px, r1_pz;

    always_ff @(posedge i_clk) begin
        r1_col <= i_s_axis_tdata[7:0];
        r1_row <= i_s_axis_tdata[15:8];
        r1_val <= i_s_axis_tdata[16 +: SW];
        r1_px  <= i_s_axis_tdata[63:32];
        r1_pz  <= i_s_axis_tdata[95:64];
    end

    // ------------------------------------------------------------------
    // Stage 2: offset the position by half the terrain size.
    // ------------------------------------------------------------------
    logic [32:0] sum_x, sum_z;
    logic [31:0] r2_px, r2_pz;
    logic        r2_neg_x, r2_neg_z;

    assign sum_x = {r1_px[31], r1_px} + {2'b00, r_half_size};
    assign sum_z = {r1_pz[31], r1_pz} + {2'b00, r_half_size};

    always_ff @(posedge i_clk) begin
        r2_px    <= sum_x[31:0];
        r2_pz    <= sum_z[31:0];
        r2_neg_x <= sum_x[32];
        r2_neg_z <= sum_z[32];
        r2_col   <= r1_col;
        r2_row   <= r1_row;
        r2_val   <= r1_val;
    end

    // ------------------------------------------------------------------
    // Stage 3: scale into cell units.
    // ------------------------------------------------------------------
    logic [63:0] r3_prod_x, r3_prod_z;
    logic        r3_neg_x, r3_neg_z;

    always_ff @(posedge i_clk) begin
        r3_prod_x <= 64'(r2_px) * 64'(r_cells_per);
        r3_prod_z <= 64'(r2_pz) * 64'(r_cells_per);
        r3_neg_x  <= r2_neg_x;
        r3_neg_z  <= r2_neg_z;
        r3_col    <= r2_col;
        r3_row    <= r2_row;
        r3_val    <= r2_val;
    end

    // ------------------------------------------------------------------
    // Stage 4: cell, fraction, range check, and the store access.
    // ------------------------------------------------------------------
    logic [23:0]      cell_x, cell_z;
    logic [IDX_W-1:0] x0, x1, z0, z1;
    logic             off_now;
    logic             ld_wr;
    logic [1:0]       ld_bank;
    logic [BANK_ADDR_W-1:0] ld_addr;

    assign cell_x  = r3_prod_x[63:40];
    assign cell_z  = r3_prod_z[63:40];
    assign x0      = cell_x[IDX_W-1:0];
    assign z0      = cell_z[IDX_W-1:0];
    assign x1      = x0 + 1'b1;
    assign z1      = z0 + 1'b1;
    assign off_now = r3_neg_x || r3_neg_z
                  || (cell_x >= 24'(GRID_CELLS)) || (cell_z >= 24'(GRID_CELLS));

    assign ld_wr   = r3_vld && (r3_func == FUNC_LOAD);
    assign ld_bank = {r3_row[0], r3_col[0]};
    assign ld_addr = {r3_row[IDX_W-1:1], r3_col[IDX_W-1:1]};

    logic [SW-1:0] bank_rd [NUM_BANKS];

    // Four banks by row and column parity; the four corners of a cell
    // always fall in four different banks.
    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        localparam logic PC = 1'(g % 2);
        localparam logic PR = 1'(g / 2);

        logic [SW-1:0]          r_mem [BANK_DEPTH];
        logic [SW-1:0]          r_rd;
        logic [IDX_W-1:0]       rd_col, rd_row;
        logic [BANK_ADDR_W-1:0] rd_addr;

        assign rd_col  = (x0[0] == PC) ? x0 : x1;
        assign rd_row  = (z0[0] == PR) ? z0 : z1;
        assign rd_addr = {rd_row[IDX_W-1:1], rd_col[IDX_W-1:1]};

        always_ff @(posedge i_clk) begin
            if (ld_wr && (ld_bank == 2'(g))) begin
                r_mem[ld_addr] <= r3_val;
            end
            r_rd <= r_mem[rd_addr];
        end

        assign bank_rd[g] = r_rd;
    end

    logic [15:0] r4_fx, r4_fz;
    logic        r4_px0, r4_pz0;
    logic        r4_off;

    always_ff @(posedge i_clk) begin
        r4_fx  <= r3_prod_x[39:24];
        r4_fz  <= r3_prod_z[39:24];
        r4_px0 <= x0[0];
        r4_pz0 <= z0[0];
        r4_off <= off_now;
    end

    // ------------------------------------------------------------------
    // Stage 5: choose the triangle and weigh its corners.
    // ------------------------------------------------------------------
    logic [SW-1:0] h00, h10, h01, h11;
    logic [16:0]   fsum;
    logic          lower;
    logic [SW-1:0] op_a, op_b;
    logic [16:0]   w_a, w_b, w_c;
    logic [WPROD_W-1:0] r5_pa, r5_pb, r5_pc;
    logic          r5_off;

    assign h00   = bank_rd[{r4_pz0,        r4_px0}];
    assign h10   = bank_rd[{r4_pz0,        ~r4_px0}];
    assign h01   = bank_rd[{~r4_pz0,       r4_px0}];
    assign h11   = bank_rd[{~r4_pz0,       ~r4_px0}];
    assign fsum  = {1'b0, r4_fx} + {1'b0, r4_fz};
    assign lower = (fsum <= ONE_Q16);

    always_comb begin
        if (lower) begin
            op_a = h00;
            op_b = h10;
            w_a  = ONE_Q16 - fsum;
            w_b  = {1'b0, r4_fx};
            w_c  = {1'b0, r4_fz};
        end else begin
            op_a = h10;
            op_b = h11;
            w_a  = ONE_Q16 - {1'b0, r4_fz};
            w_b  = fsum - ONE_Q16;
            w_c  = ONE_Q16 - {1'b0, r4_fx};
        end
    end

    always_ff @(posedge i_clk) begin
        r5_pa  <= WPROD_W'(op_a) * WPROD_W'(w_a);
        r5_pb  <= WPROD_W'(op_b) * WPROD_W'(w_b);
        r5_pc  <= WPROD_W'(h01)  * WPROD_W'(w_c);
        r5_off <= r4_off;
    end

    // ------------------------------------------------------------------
    // Stage 6: sum the blend and round it to Q0.16.
    // ------------------------------------------------------------------
    logic [BLEND_W-1:0] blend_rnd;
    logic [B16_W-1:0]   r6_b16;
    logic               r6_off;

    assign blend_rnd = BLEND_W'(r5_pa) + BLEND_W'(r5_pb) + BLEND_W'(r5_pc)
                     + (BLEND_W'(1) << (SAMPLE_BITS - 1));

    always_ff @(posedge i_clk) begin
        r6_b16 <= B16_W'(blend_rnd >> SAMPLE_BITS);
        r6_off <= r5_off;
    end

    // ------------------------------------------------------------------
    // Stage 7: apply the terrain height gain.
    // ------------------------------------------------------------------
    logic [GPROD_W-1:0] r7_prod;
    logic               r7_off;

    always_ff @(posedge i_clk) begin
        r7_prod <= GPROD_W'(r6_b16) * GPROD_W'(r_gain);
        r7_off  <= r6_off;
    end

    // ------------------------------------------------------------------
    // Stage 8: round the scaled height to Q16.16.
    // ------------------------------------------------------------------
    logic [GPROD_W:0]    gain_rnd;
    logic [SCALED_W-1:0] r8_scaled;
    logic                r8_off;

    assign gain_rnd = {1'b0, r7_prod} + (GPROD_W + 1)'(32'h8000);

    always_ff @(posedge i_clk) begin
        r8_scaled <= gain_rnd[GPROD_W:16];
        r8_off    <= r7_off;
    end

    // ------------------------------------------------------------------
    // Stage 9: add the eye offset, saturate (zero when off the grid), and queue the result.
    // ------------------------------------------------------------------
    logic [SCALED_W:0] total;
    logic [31:0]       height;

    assign total = {1'b0, r8_scaled} + (SCALED_W + 1)'({r_eye, 1'b0});

    always_comb begin
        if (r8_off) begin
            height = '0;
        end else if (total > (SCALED_W + 1)'(HEIGHT_MAX)) begin
            height = HEIGHT_MAX;
        end else begin
            height = total[31:0];
        end
    end

    // Result queue: the output register stage of the block.
    logic [32:0]           r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_fill;
    logic                  push;

    assign push = r8_vld;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= {r8_off, height};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !out_acc) begin
                r_fill <= r_fill + 1'b1;
            end else if (!push && out_acc) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign o_m_axis_tvalid = (r_fill != '0) && (r_credit != '0 || r_credit_q);
    assign o_m_axis_tdata  = r_fifo[r_rd_ptr][31:0];
    assign o_m_axis_tuser  = r_fifo[r_rd_ptr][32];

endmodule
